// File: hw/rtl/fpm_pkg.sv
// Shared types and constants for the single-precision multiplier.
package fpm_pkg;
    localparam int unsigned FpWidth  = 32;
    localparam int unsigned ManWidth = 24;
    localparam int unsigned ProdWidth = 48;
    localparam int unsigned ExpWidth = 10;
    localparam logic [31:0] FpInf    = 32'h7F80_0000;
    localparam logic [31:0] FpDefNan = 32'h7FC0_0000;
    localparam logic [31:0] FpQuiet  = 32'h0040_0000;
    localparam logic [31:0] FpSign   = 32'h8000_0000;

    typedef struct packed {
        logic signed [ExpWidth-1:0] exp;
        logic [ManWidth-1:0]        man;
    } t_unp;

    typedef struct packed {
        logic        special;
        logic [31:0] value;
    } t_spec;
endpackage

// File: hw/rtl/fpm_unpack.sv
// Operand unpack: hidden bit and subnormal normalization.
module fpm_unpack
    import fpm_pkg::*;
(
    input  logic [31:0] i_op,
    output t_unp        o_unp
);
    logic [7:0]  ex;
    logic [23:0] mx;
    logic [4:0]  lz;
    logic        found;

    assign ex = i_op[30:23];
    assign mx = {1'b0, i_op[22:0]};

    always_comb begin
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && mx[i]) begin
                found = 1'b1;
                lz    = 5'(23 - i);
            end
        end
    end

    always_comb begin
        if (ex == 8'd0) begin
            o_unp.exp = ExpWidth'(signed'(11'sd1 - signed'({6'd0, lz})));
            o_unp.man = mx << lz;
        end else begin
            o_unp.exp = signed'({2'b00, ex});
            o_unp.man = {1'b1, i_op[22:0]};
        end
    end
endmodule

// File: hw/rtl/fpm_norm.sv
// Product normalization, overflow detect and denormalizing shift with sticky.
module fpm_norm
    import fpm_pkg::*;
(
    input  logic [ProdWidth-1:0]        i_prod,
    input  logic signed [ExpWidth-1:0]  i_exp,
    output logic [ProdWidth-1:0]        o_prod,
    output logic [7:0]                  o_exp,
    output logic                        o_ovf
);
    logic [ProdWidth-1:0]       p1;
    logic [ProdWidth-1:0]       p_sh;
    logic signed [ExpWidth:0]   e1;
    logic signed [ExpWidth:0]   sh;
    logic [5:0]                 shamt;

    always_comb begin
        if (i_prod[ProdWidth-1]) begin
            p1 = i_prod;
            e1 = ExpWidth'(1) + ExpWidth'(0) + {i_exp[ExpWidth-1], i_exp};
        end else begin
            p1 = i_prod << 1;
            e1 = {i_exp[ExpWidth-1], i_exp};
        end
        sh    = 11'sd1 - e1;
        shamt = sh[5:0];
        p_sh  = p1 >> shamt;
        o_ovf = (e1 >= 11'sd255);
        o_prod = p1;
        o_exp  = 8'd0;
        if (e1 <= 11'sd0) begin
            if (sh >= 11'sd50) begin
                o_prod = ProdWidth'(1);
            end else begin
                o_prod = p_sh | ProdWidth'((p_sh << shamt) != p1);
            end
        end else begin
            o_exp = e1[7:0];
        end
    end
endmodule

// File: hw/rtl/fpm_round.sv
// Round to nearest even and pack.
module fpm_round
    import fpm_pkg::*;
(
    input  logic [ProdWidth-1:0] i_prod,
    input  logic [7:0]           i_exp,
    input  logic                 i_sign,
    output logic [31:0]          o_word
);
    logic [23:0] sig;
    logic [24:0] sig_r;
    logic        rnd;
    logic [31:0] bits;

    assign sig   = i_prod[47:24];
    assign rnd   = i_prod[23] && ((i_prod[22:0] != 23'd0) || sig[0]);
    assign sig_r = {1'b0, sig} + 25'(rnd);

    always_comb begin
        bits = ({24'd0, (i_exp >= 8'd1) ? i_exp - 8'd1 : 8'd0} << 23) + {7'd0, sig_r};
        if (bits >= FpInf) begin
            o_word = {i_sign, FpInf[30:0]};
        end else begin
            o_word = {i_sign, bits[30:0]};
        end
    end
endmodule

// File: hw/rtl/fp32_multiplier_top.sv
// Top level: four-stage pipelined IEEE 754 single-precision multiplier.
//
// Input channel: i_valid, i_op_a, i_op_b; this block drives o_stall.
// Output channel: o_valid, o_product; the receiver drives i_stall.
// A word is taken on a rising edge with valid high and stall low.
// Stages: unpack and special-case detect, 24x24 significand multiply,
// normalize and denormalize with sticky, round and pack.
// Each word passes the stage registers r1, r2, r3 and r4 in order, and
// o_valid follows r4_v.
// Throughput is one word per cycle while the receiver does not stall; the
// 24x24 multiply stage sets the clock period.
// When the receiver stalls while a result is held, the whole pipe freezes
// and o_stall rises; nothing is lost or repeated.
// Synchronous reset (i_rst_n low) clears all valid bits; no result is
// shown until new words enter. The data registers are not reset.
module fp32_multiplier_top
    import fpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_op_a,
    input  logic [31:0] i_op_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_product
);
    logic adv;
    t_unp ua, ub;
    t_spec n_spec;

    logic r1_v, r2_v, r3_v, r4_v;
    t_spec r1_spec, r2_spec, r3_spec;
    logic r1_sign, r2_sign, r3_sign;
    t_unp r1_a, r1_b;
    logic [ProdWidth-1:0] r2_p, r3_p;
    logic signed [ExpWidth-1:0] r2_e;
    logic [7:0] r3_e;
    logic [31:0] r4_out;

    logic [ProdWidth-1:0] n_p3;
    logic [7:0] n_e3;
    logic ovf;
    logic [31:0] n_out;

    assign adv     = !(r4_v && i_stall);
    assign o_stall = !adv;
    assign o_valid = r4_v;
    assign o_product = r4_out;

    fpm_unpack u_unp_a (.i_op(i_op_a), .o_unp(ua));
    fpm_unpack u_unp_b (.i_op(i_op_b), .o_unp(ub));

    always_comb begin
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        a_nan  = (i_op_a[30:23] == 8'hFF) && (i_op_a[22:0] != 23'd0);
        b_nan  = (i_op_b[30:23] == 8'hFF) && (i_op_b[22:0] != 23'd0);
        a_inf  = (i_op_a[30:0] == FpInf[30:0]);
        b_inf  = (i_op_b[30:0] == FpInf[30:0]);
        a_zero = (i_op_a[30:0] == 31'd0);
        b_zero = (i_op_b[30:0] == 31'd0);
        n_spec.special = 1'b1;
        if (a_nan) begin
            n_spec.value = i_op_a | FpQuiet;
        end else if (b_nan) begin
            n_spec.value = i_op_b | FpQuiet;
        end else if ((a_inf || b_inf) && (a_zero || b_zero)) begin
            n_spec.value = FpDefNan;
        end else if (a_inf || b_inf) begin
            n_spec.value = {i_op_a[31] ^ i_op_b[31], FpInf[30:0]};
        end else if (a_zero || b_zero) begin
            n_spec.value = {i_op_a[31] ^ i_op_b[31], 31'd0};
        end else begin
            n_spec.special = 1'b0;
            n_spec.value   = 32'd0;
        end
    end

    fpm_norm u_norm (
        .i_prod(r2_p), .i_exp(r2_e), .o_prod(n_p3), .o_exp(n_e3), .o_ovf(ovf)
    );

    fpm_round u_round (
        .i_prod(r3_p), .i_exp(r3_e), .i_sign(r3_sign), .o_word(n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_spec <= n_spec;
            r1_sign <= i_op_a[31] ^ i_op_b[31];
            r1_a    <= ua;
            r1_b    <= ub;

            r2_spec <= r1_spec;
            r2_sign <= r1_sign;
            r2_p    <= {24'd0, r1_a.man} * {24'd0, r1_b.man};
            r2_e    <= r1_a.exp + r1_b.exp - ExpWidth'(127);

            r3_sign <= r2_sign;
            r3_p    <= n_p3;
            r3_e    <= n_e3;
            if (!r2_spec.special && ovf) begin
                r3_spec <= '{special: 1'b1, value: {r2_sign, FpInf[30:0]}};
            end else begin
                r3_spec <= r2_spec;
            end

            r4_out <= r3_spec.special ? r3_spec.value : n_out;
        end
    end
endmodule

// File: hw/rtl/fpm_checker.sv
// Port-level checker for the multiplier, bound to the top level.
module fpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_product
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without held result");
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped");
    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_product))
        else $error("stalled word changed");
endmodule

bind fp32_multiplier_top fpm_checker u_fpm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_product(o_product)
);
